// ===== rtl/mrc_pkg.sv =====
// Package for the Modbus RTU response checker.
// Holds the item codes, protocol constants and the item and result structs.
// No dependencies.
package mrc_pkg;

  // Input item codes
  typedef enum logic [1:0] {
    FUNC_BEGIN   = 2'd0,
    FUNC_BYTE    = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  // Result item kinds
  typedef enum logic [1:0] {
    KIND_REG    = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_CRC_ERR   = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_EXCEPTION = 3'd5
  } status_e;

  // Protocol constants
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  EXC_BIT         = 8'h80;
  localparam logic [15:0] MAX_READ_REGS   = 16'd125;
  localparam logic [7:0]  MAX_SLAVE       = 8'd247;
  localparam logic [7:0]  FC_READ         = 8'h03;
  localparam logic [7:0]  FC_WRITE_ONE    = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [7:0]  MULTI_COUNT_LO  = 8'h02;
  localparam logic [8:0]  READ_LEN_BASE   = 9'd5;
  localparam logic [8:0]  EXC_FRAME_LEN   = 9'd5;
  localparam logic [8:0]  WRITE_FRAME_LEN = 9'd8;
  localparam logic [7:0]  DEF_RETRY_LIMIT = 8'd3;

  // Error flag bit positions
  localparam int unsigned FL_SLAVE = 0;
  localparam int unsigned FL_EXC   = 1;
  localparam int unsigned FL_FUNC  = 2;
  localparam int unsigned FL_FIELD = 3;

  typedef struct packed {
    func_e       func;
    logic [7:0]  node_id;
    logic [7:0]  function_code;
    logic [15:0] address;
    logic [15:0] count_or_value;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  reg_index;
    logic [15:0] reg_value;
    status_e     status;
    logic        last;
  } result_t;

endpackage

// ===== rtl/modbus_rtu_response_checker.sv =====
// Top level of the Modbus RTU master response checker.
// Uses mrc_pkg and mrc_core; holds the input stage, result register and retry limit.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries begin, received byte and
//   timeout items. A begin item arms the checker for one transaction; bytes
//   follow one per item; a timeout item asks for a resend or ends the
//   transaction. The output channel (out_valid_o/out_ready_i) carries register
//   words as they arrive, resend requests and one final status with last_o set.
//   cfg_we_i/cfg_wdata_i write the retry limit (zero acts as three); write it
//   only while no transaction is in flight.
// Timing:
//   An item is registered in the input stage and processed once the result
//   register is empty or being drained; its result is registered there. One
//   item per cycle is sustained while out_ready_i stays high; the CRC byte step
//   and the checks are combinational between input stage and result register.
// Reset:
//   Clears the transaction state (idle), both stages and sets the retry
//   limit to three.
// Stall:
//   While a result waits on out_ready_i, one more item may enter the input
//   stage; after that in_ready_o drops until the result is taken.
module modbus_rtu_response_checker import mrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  node_id_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] address_i,
  input  logic [15:0] count_or_value_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [6:0]  reg_index_o,
  output logic [15:0] reg_value_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  logic [7:0] retry_limit_q;
  logic       stg_valid_q;
  item_t      stg_item_q;
  logic       out_valid_q;
  result_t    out_res_q;
  logic       fire;
  logic       res_valid;
  result_t    res;

  assign fire       = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || fire;

  // Hold the retry limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= DEF_RETRY_LIMIT;
    end else if (cfg_we_i) begin
      retry_limit_q <= cfg_wdata_i;
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_item_q <= '{func: func_e'(func_i), node_id: node_id_i,
                      function_code: function_code_i, address: address_i,
                      count_or_value: count_or_value_i, rx_byte: rx_byte_i};
    end
  end

  mrc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (stg_item_q),
    .retry_limit_i (retry_limit_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Load or drain the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_res_q.kind;
  assign reg_index_o = out_res_q.reg_index;
  assign reg_value_o = out_res_q.reg_value;
  assign status_o    = out_res_q.status;
  assign last_o      = out_res_q.last;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while stage and result register are both full");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> stg_valid_q)
    else $error("accepted item lost from the input stage");

  a_last_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.last == (out_res_q.kind == KIND_STATUS)))
    else $error("last flag does not match final status kind");

  a_word_only_on_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.kind != KIND_REG) |->
      (out_res_q.reg_value == 16'd0 && out_res_q.reg_index == 7'd0))
    else $error("register payload on a non-register result");
`endif

endmodule

// ===== rtl/mrc_crc_step.sv =====
// CRC-16/MODBUS update over one byte, bit-parallel.
// Uses mrc_pkg for the reflected polynomial.
module mrc_crc_step import mrc_pkg::*; (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  // Fold in the byte, then shift out eight bits LSB first
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// ===== rtl/mrc_core.sv =====
// Transaction state and per-item decision logic of the response checker.
// Uses mrc_pkg and mrc_crc_step.
module mrc_core import mrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  item_t      item_i,
  input  logic [7:0] retry_limit_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic        busy_q, busy_d;
  logic [7:0]  attempt_q, attempt_d;
  logic [8:0]  pos_q, pos_d;
  logic [8:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  want_slave_q, want_slave_d;
  logic [7:0]  want_func_q, want_func_d;
  logic [15:0] want_addr_q, want_addr_d;
  logic [15:0] want_word_q, want_word_d;
  logic [3:0]  flags_q, flags_d;
  logic [7:0]  held_q, held_d;

  logic [15:0] crc_next;
  logic [9:0]  pos_plus2;
  logic [9:0]  len_ext;
  logic [8:0]  pos_m4;
  logic [15:0] got_crc;
  logic [7:0]  lim;
  logic        bad_arg;
  logic        chk;
  logic [7:0]  exp_byte;

  mrc_crc_step u_crc (
    .crc_i  (crc_q),
    .data_i (item_i.rx_byte),
    .crc_o  (crc_next)
  );

  assign pos_plus2 = {1'b0, pos_q} + 10'd2;
  assign len_ext   = {1'b0, len_q};
  assign pos_m4    = pos_q - 9'd4;
  assign got_crc   = {item_i.rx_byte, held_q};
  assign lim       = (retry_limit_i == 8'd0) ? DEF_RETRY_LIMIT : retry_limit_i;

  // Check the begin arguments
  always_comb begin
    bad_arg = (item_i.node_id == 8'd0) || (item_i.node_id > MAX_SLAVE);
    if (item_i.function_code != FC_READ && item_i.function_code != FC_WRITE_ONE &&
        item_i.function_code != FC_WRITE_MULTI) begin
      bad_arg = 1'b1;
    end
    if (item_i.function_code == FC_READ &&
        (item_i.count_or_value == 16'd0 || item_i.count_or_value > MAX_READ_REGS)) begin
      bad_arg = 1'b1;
    end
  end

  // Expected byte at the current position, for the echo and byte count checks
  always_comb begin
    chk      = 1'b0;
    exp_byte = 8'h00;
    if (want_func_q == FC_READ) begin
      if (pos_q == 9'd2) begin
        chk      = 1'b1;
        exp_byte = {want_word_q[6:0], 1'b0};
      end
    end else begin
      case (pos_q)
        9'd2: begin
          chk      = 1'b1;
          exp_byte = want_addr_q[15:8];
        end
        9'd3: begin
          chk      = 1'b1;
          exp_byte = want_addr_q[7:0];
        end
        9'd4: begin
          chk      = 1'b1;
          exp_byte = (want_func_q == FC_WRITE_ONE) ? want_word_q[15:8] : 8'h00;
        end
        9'd5: begin
          chk      = 1'b1;
          exp_byte = (want_func_q == FC_WRITE_ONE) ? want_word_q[7:0] : MULTI_COUNT_LO;
        end
        default: begin
          chk = 1'b0;
        end
      endcase
    end
  end

  // Decide next state and the result of the item
  always_comb begin
    busy_d      = busy_q;
    attempt_d   = attempt_q;
    pos_d       = pos_q;
    len_d       = len_q;
    crc_d       = crc_q;
    want_slave_d = want_slave_q;
    want_func_d = want_func_q;
    want_addr_d = want_addr_q;
    want_word_d = want_word_q;
    flags_d     = flags_q;
    held_d      = held_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_REG, reg_index: 7'd0, reg_value: 16'd0,
                    status: ST_OK, last: 1'b0};

    case (item_i.func)
      FUNC_BEGIN: begin
        if (bad_arg) begin
          busy_d      = 1'b0;
          res_valid_o = 1'b1;
          res_o.kind   = KIND_STATUS;
          res_o.status = ST_INVALID;
          res_o.last   = 1'b1;
        end else begin
          want_slave_d = item_i.node_id;
          want_func_d  = item_i.function_code;
          want_addr_d  = item_i.address;
          want_word_d  = item_i.count_or_value;
          attempt_d    = 8'd1;
          busy_d       = 1'b1;
          pos_d        = 9'd0;
          crc_d        = CRC_INIT;
          flags_d      = 4'd0;
          held_d       = 8'd0;
          len_d = (item_i.function_code == FC_READ) ?
                  READ_LEN_BASE + {item_i.count_or_value[7:0], 1'b0} : WRITE_FRAME_LEN;
        end
      end

      FUNC_TIMEOUT: begin
        if (busy_q) begin
          res_valid_o = 1'b1;
          if (attempt_q < lim) begin
            attempt_d    = attempt_q + 8'd1;
            pos_d        = 9'd0;
            crc_d        = CRC_INIT;
            flags_d      = 4'd0;
            held_d       = 8'd0;
            len_d = (want_func_q == FC_READ) ?
                    READ_LEN_BASE + {want_word_q[7:0], 1'b0} : WRITE_FRAME_LEN;
            res_o.kind   = KIND_RESEND;
            res_o.status = ST_TIMEOUT;
          end else begin
            busy_d       = 1'b0;
            res_o.kind   = KIND_STATUS;
            res_o.status = ST_TIMEOUT;
            res_o.last   = 1'b1;
          end
        end
      end

      FUNC_BYTE: begin
        if (busy_q) begin
          pos_d = pos_q + 9'd1;
          if (pos_plus2 < len_ext) begin
            // Header and data bytes: run the CRC and check fields
            crc_d = crc_next;
            if (pos_q == 9'd0) begin
              if (item_i.rx_byte != want_slave_q) flags_d[FL_SLAVE] = 1'b1;
            end else if (pos_q == 9'd1) begin
              if (item_i.rx_byte == (want_func_q | EXC_BIT)) begin
                flags_d[FL_EXC] = 1'b1;
                len_d           = EXC_FRAME_LEN;
              end else if (item_i.rx_byte != want_func_q) begin
                flags_d[FL_FUNC] = 1'b1;
              end
            end else if (!flags_q[FL_EXC]) begin
              if (chk && item_i.rx_byte != exp_byte) flags_d[FL_FIELD] = 1'b1;
              if (want_func_q == FC_READ && pos_q >= 9'd3) begin
                if (pos_q[0]) begin
                  held_d = item_i.rx_byte;
                end else begin
                  res_valid_o     = 1'b1;
                  res_o.kind      = KIND_REG;
                  res_o.reg_index = pos_m4[7:1];
                  res_o.reg_value = {held_q, item_i.rx_byte};
                end
              end
            end
          end else if (pos_plus2 == len_ext) begin
            // Low CRC byte
            held_d = item_i.rx_byte;
          end else begin
            // High CRC byte: rank and report
            busy_d      = 1'b0;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_STATUS;
            res_o.last  = 1'b1;
            if (got_crc != crc_q) begin
              res_o.status = ST_CRC_ERR;
            end else if (flags_q[FL_SLAVE]) begin
              res_o.status = ST_MISMATCH;
            end else if (flags_q[FL_EXC]) begin
              res_o.status = ST_EXCEPTION;
            end else if (flags_q[FL_FUNC] || flags_q[FL_FIELD]) begin
              res_o.status = ST_MISMATCH;
            end else begin
              res_o.status = ST_OK;
            end
          end
        end
      end

      default: begin
        busy_d = busy_q;
      end
    endcase
  end

  // Advance the state on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      attempt_q    <= 8'd0;
      pos_q        <= 9'd0;
      len_q        <= 9'd0;
      crc_q        <= CRC_INIT;
      want_slave_q <= 8'd0;
      want_func_q  <= 8'd0;
      want_addr_q  <= 16'd0;
      want_word_q  <= 16'd0;
      flags_q      <= 4'd0;
      held_q       <= 8'd0;
    end else if (fire_i) begin
      busy_q       <= busy_d;
      attempt_q    <= attempt_d;
      pos_q        <= pos_d;
      len_q        <= len_d;
      crc_q        <= crc_d;
      want_slave_q <= want_slave_d;
      want_func_q  <= want_func_d;
      want_addr_q  <= want_addr_d;
      want_word_q  <= want_word_d;
      flags_q      <= flags_d;
      held_q       <= held_d;
    end
  end

endmodule

// ===== tb/modbus_rtu_response_checker_test.sv =====
// Self-checking testbench for the Modbus RTU response checker.
// Predicts every result item in a small scoreboard class, then drives requests and response frames.
// Depends on mrc_pkg and modbus_rtu_response_checker.
import mrc_pkg::*;

class mrc_scoreboard;
  logic [7:0]  retry_limit;
  bit          busy;
  logic [7:0]  attempts;
  int unsigned frame_pos;
  int unsigned frame_len;
  logic [15:0] crc;
  logic [7:0]  want_slave;
  logic [7:0]  want_fc;
  logic [15:0] want_addr;
  logic [15:0] want_word;
  logic [3:0]  flags;
  logic [7:0]  held;
  result_t     expected_q[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    retry_limit = DEF_RETRY_LIMIT;
    busy = 1'b0;
    attempts = '0;
    frame_pos = 0;
    frame_len = 0;
    crc = CRC_INIT;
    want_slave = '0;
    want_fc = '0;
    want_addr = '0;
    want_word = '0;
    flags = '0;
    held = '0;
    errors = 0;
    checked = 0;
  endfunction

  // One byte of CRC-16/MODBUS, reflected polynomial
  static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function void set_limit(logic [7:0] v);
    retry_limit = v;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // Arm for a fresh response frame of the requested function
  function void restart_frame();
    frame_pos = 0;
    crc = CRC_INIT;
    flags = '0;
    held = '0;
    if (want_fc == FC_READ) begin
      frame_len = int'(READ_LEN_BASE) + 2 * int'(want_word);
    end else begin
      frame_len = int'(WRITE_FRAME_LEN);
    end
  endfunction

  function void push_result(kind_e k, logic [6:0] idx, logic [15:0] v, status_e s, logic l);
    result_t r;
    r.kind = k;
    r.reg_index = idx;
    r.reg_value = v;
    r.status = s;
    r.last = l;
    expected_q.push_back(r);
  endfunction

  // Byte count or echo byte expected at a frame position; returns 0 where unchecked
  function bit field_byte(int unsigned pos, output logic [7:0] e);
    e = '0;
    if (want_fc == FC_READ) begin
      e = {want_word[6:0], 1'b0};
      return pos == 2;
    end
    case (pos)
      2: e = want_addr[15:8];
      3: e = want_addr[7:0];
      4: e = (want_fc == FC_WRITE_ONE) ? want_word[15:8] : 8'h00;
      5: e = (want_fc == FC_WRITE_ONE) ? want_word[7:0] : MULTI_COUNT_LO;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Advance the predicted state by one accepted item
  function void note_item(item_t it);
    logic [7:0]  b;
    logic [7:0]  e;
    logic [15:0] got;
    int unsigned pos;
    int unsigned lim;
    status_e     st;
    bit          bad;
    case (it.func)
      FUNC_BEGIN: begin
        bad = (it.node_id == 8'd0) || (it.node_id > MAX_SLAVE);
        if (!(it.function_code inside {FC_READ, FC_WRITE_ONE, FC_WRITE_MULTI})) bad = 1'b1;
        if (it.function_code == FC_READ &&
            (it.count_or_value == 16'd0 || it.count_or_value > MAX_READ_REGS)) bad = 1'b1;
        if (bad) begin
          busy = 1'b0;
          push_result(KIND_STATUS, '0, '0, ST_INVALID, 1'b1);
          return;
        end
        want_slave = it.node_id;
        want_fc = it.function_code;
        want_addr = it.address;
        want_word = it.count_or_value;
        attempts = 8'd1;
        busy = 1'b1;
        restart_frame();
      end
      FUNC_TIMEOUT: begin
        lim = (retry_limit == 8'd0) ? DEF_RETRY_LIMIT : retry_limit;
        if (!busy) return;
        if (attempts < lim) begin
          attempts = attempts + 8'd1;
          restart_frame();
          push_result(KIND_RESEND, '0, '0, ST_TIMEOUT, 1'b0);
        end else begin
          busy = 1'b0;
          push_result(KIND_STATUS, '0, '0, ST_TIMEOUT, 1'b1);
        end
      end
      FUNC_BYTE: begin
        if (!busy) return;
        b = it.rx_byte;
        pos = frame_pos;
        if (pos + 2 < frame_len) begin
          crc = crc_byte(crc, b);
          if (pos == 0) begin
            if (b != want_slave) flags[FL_SLAVE] = 1'b1;
          end else if (pos == 1) begin
            // exception reply shortens the frame to five bytes
            if (b == (want_fc | EXC_BIT)) begin
              flags[FL_EXC] = 1'b1;
              frame_len = int'(EXC_FRAME_LEN);
            end else if (b != want_fc) begin
              flags[FL_FUNC] = 1'b1;
            end
          end else if (!flags[FL_EXC]) begin
            if (field_byte(pos, e) && b != e) flags[FL_FIELD] = 1'b1;
            if (want_fc == FC_READ && pos >= 3) begin
              if (pos % 2 == 1) begin
                held = b;
              end else begin
                push_result(KIND_REG, 7'((pos - 4) >> 1), {held, b}, ST_OK, 1'b0);
              end
            end
          end
        end else if (pos + 2 == frame_len) begin
          held = b;
        end else begin
          // trailing CRC, low byte first; rank the errors
          got = {b, held};
          if (got != crc) st = ST_CRC_ERR;
          else if (flags[FL_SLAVE]) st = ST_MISMATCH;
          else if (flags[FL_EXC]) st = ST_EXCEPTION;
          else if (flags[FL_FUNC] || flags[FL_FIELD]) st = ST_MISMATCH;
          else st = ST_OK;
          busy = 1'b0;
          push_result(KIND_STATUS, '0, '0, st, 1'b1);
        end
        frame_pos = pos + 1;
      end
      default: ;
    endcase
  endfunction

  function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare one accepted result item with the oldest prediction
  function void check_result(result_t got);
    result_t want;
    checked++;
    if (expected_q.size() == 0) begin
      $error("result with nothing predicted: kind %0d status %0d", got.kind, got.status);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    cmp_field("kind", 16'(want.kind), 16'(got.kind));
    cmp_field("reg_index", 16'(want.reg_index), 16'(got.reg_index));
    cmp_field("reg_value", want.reg_value, got.reg_value);
    cmp_field("status", 16'(want.status), 16'(got.status));
    cmp_field("last", 16'(want.last), 16'(got.last));
  endfunction
endclass

module modbus_rtu_response_checker_test;

  localparam int unsigned RAND_ITEMS     = 900;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam logic [7:0]  FC_UNSUPPORTED = 8'h04;

  typedef enum {
    RSP_GOOD,
    RSP_EXCEPTION,
    RSP_BAD_SLAVE,
    RSP_BAD_FUNC,
    RSP_BAD_FIELD,
    RSP_BAD_CRC
  } rsp_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  item_t       cur_item = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  kind;
  logic [6:0]  reg_index;
  logic [15:0] reg_value;
  logic [2:0]  status;
  logic        last;

  mrc_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_sent = 0;
  logic [7:0]  cur_limit = DEF_RETRY_LIMIT;
  logic [7:0]  limits[NUM_PHASES] = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd2, 8'd3};

  // current request and its response frame
  logic [7:0]  req_slave;
  logic [7:0]  req_fc;
  logic [15:0] req_addr;
  logic [15:0] req_word;
  logic [7:0]  frame_q[$];

  modbus_rtu_response_checker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (cur_item.func),
    .node_id_i       (cur_item.node_id),
    .function_code_i (cur_item.function_code),
    .address_i       (cur_item.address),
    .count_or_value_i(cur_item.count_or_value),
    .rx_byte_i       (cur_item.rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .reg_index_o     (reg_index),
    .reg_value_o     (reg_value),
    .status_o        (status),
    .last_o          (last)
  );

  always #10 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Track accepted items on both channels; stop on a hang
  always @(posedge clk) begin
    result_t seen;
    if (!rst_n) begin
      stall_cycles = 0;
    end else begin
      if (in_valid && in_ready) sb.note_item(cur_item);
      if (out_valid && out_ready) begin
        seen.kind = kind_e'(kind);
        seen.reg_index = reg_index;
        seen.reg_value = reg_value;
        seen.status = status_e'(status);
        seen.last = last;
        sb.check_result(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic item_t rand_item(func_e f);
    item_t it;
    it.func = f;
    it.node_id = 8'($urandom);
    it.function_code = 8'($urandom);
    it.address = 16'($urandom);
    it.count_or_value = 16'($urandom);
    it.rx_byte = 8'($urandom);
    return it;
  endfunction

  // Build the slave's reply to the current request, with at most one chosen defect
  function automatic void build_frame(rsp_e mode);
    logic [15:0] c;
    logic [7:0]  fb;
    int unsigned at;
    frame_q.delete();
    frame_q.push_back(mode == RSP_BAD_SLAVE ?
                      req_slave ^ 8'($urandom_range(1, 255)) : req_slave);
    fb = req_fc;
    if (mode == RSP_EXCEPTION) begin
      fb = req_fc | EXC_BIT;
    end else if (mode == RSP_BAD_FUNC) begin
      fb = 8'($urandom);
      if (fb == req_fc || fb == (req_fc | EXC_BIT)) fb = fb ^ 8'h01;
    end
    frame_q.push_back(fb);
    if (mode == RSP_EXCEPTION) begin
      frame_q.push_back(8'($urandom_range(1, 4)));
    end else if (req_fc == FC_READ) begin
      frame_q.push_back({req_word[6:0], 1'b0});
      repeat (2 * int'(req_word)) frame_q.push_back(8'($urandom));
    end else begin
      frame_q.push_back(req_addr[15:8]);
      frame_q.push_back(req_addr[7:0]);
      if (req_fc == FC_WRITE_ONE) begin
        frame_q.push_back(req_word[15:8]);
        frame_q.push_back(req_word[7:0]);
      end else begin
        frame_q.push_back(8'h00);
        frame_q.push_back(MULTI_COUNT_LO);
      end
    end
    if (mode == RSP_BAD_FIELD) begin
      at = (req_fc == FC_READ) ? 2 : $urandom_range(2, 5);
      frame_q[at] = frame_q[at] ^ 8'(1 << $urandom_range(7));
    end
    c = CRC_INIT;
    foreach (frame_q[i]) c = sb.crc_byte(c, frame_q[i]);
    if (mode == RSP_BAD_CRC) c = c ^ 16'(1 << $urandom_range(15));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cur_item <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_begin(input logic [7:0] sl, input logic [7:0] fc,
                            input logic [15:0] ad, input logic [15:0] cv);
    item_t it;
    it = rand_item(FUNC_BEGIN);
    it.node_id = sl;
    it.function_code = fc;
    it.address = ad;
    it.count_or_value = cv;
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    item_t it;
    it = rand_item(FUNC_BYTE);
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_timeout();
    send_item(rand_item(FUNC_TIMEOUT));
  endtask

  // Send the first n bytes of the frame, with an occasional no-op item mixed in
  task automatic send_prefix(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(49) == 0) send_item(rand_item(FUNC_NONE));
      send_byte(frame_q[i]);
    end
  endtask

  task automatic send_request();
    send_begin(req_slave, req_fc, req_addr, req_word);
  endtask

  // Drop valid and wait out every predicted result plus the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // End any open transaction with a rejected begin, then drain
  task automatic quiesce();
    send_begin(8'd0, FC_READ, 16'h0000, 16'd1);
    settle();
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
    cur_limit = v;
  endtask

  task automatic directed_items();
    // argument checks
    send_begin(8'd0, FC_READ, 16'h0000, 16'd1);
    send_begin(MAX_SLAVE + 8'd1, FC_READ, 16'h0000, 16'd1);
    send_begin(8'd1, FC_UNSUPPORTED, 16'h0000, 16'd1);
    send_begin(8'd5, FC_READ, 16'h1234, 16'd0);
    send_begin(8'd5, FC_READ, 16'h1234, MAX_READ_REGS + 16'd1);
    // items that an idle checker ignores
    send_byte(8'hFF);
    send_timeout();
    send_item(rand_item(FUNC_NONE));
    // clean one-register read from the highest slave at the top address
    req_slave = MAX_SLAVE;
    req_fc = FC_READ;
    req_addr = 16'hFFFF;
    req_word = 16'd1;
    send_request();
    build_frame(RSP_GOOD);
    send_prefix(frame_q.size());
    // exception reply to a multiple write
    req_slave = 8'd1;
    req_fc = FC_WRITE_MULTI;
    req_addr = 16'h0000;
    req_word = 16'h0000;
    send_request();
    build_frame(RSP_EXCEPTION);
    send_prefix(frame_q.size());
    // single write that times out once and asks for a resend
    req_slave = 8'd100;
    req_fc = FC_WRITE_ONE;
    req_addr = 16'h8001;
    req_word = 16'hFFFF;
    send_request();
    send_timeout();
  endtask

  // One request with retries and a reply, mostly well formed
  task automatic run_transaction(input bit first, input bit big_read);
    int unsigned lim;
    int unsigned tries;
    int unsigned roll;
    rsp_e        mode;
    roll = $urandom_range(99);
    if (roll < 8) begin
      send_begin(8'($urandom), $urandom_range(1) ? 8'($urandom) : FC_READ,
                 16'($urandom), 16'($urandom));
      return;
    end
    req_slave = 8'($urandom_range(1, MAX_SLAVE));
    case ($urandom_range(2))
      0: req_fc = FC_READ;
      1: req_fc = FC_WRITE_ONE;
      default: req_fc = FC_WRITE_MULTI;
    endcase
    if (big_read) req_fc = FC_READ;
    req_addr = 16'($urandom);
    if (req_fc != FC_READ) req_word = 16'($urandom);
    else if (big_read) req_word = MAX_READ_REGS;
    else if ($urandom_range(24) == 0) req_word = 16'($urandom_range(1, 125));
    else req_word = 16'($urandom_range(1, 6));
    send_request();
    // line noise, then give up on it
    if (roll < 13) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      send_timeout();
      return;
    end
    lim = (cur_limit == 8'd0) ? DEF_RETRY_LIMIT : cur_limit;
    tries = 0;
    if ((first && lim > 8) || (lim <= 8 && $urandom_range(9) == 0)) tries = lim;
    else if (lim > 1 && $urandom_range(3) == 0) tries = $urandom_range(1, (lim > 4) ? 3 : lim - 1);
    // broken-off replies before each timeout, when there are at most eight tries
    repeat (tries) begin
      if (tries <= 8) begin
        build_frame(RSP_GOOD);
        send_prefix($urandom_range(0, frame_q.size() - 1));
      end
      send_timeout();
    end
    if (tries == lim) return;
    roll = $urandom_range(99);
    if (roll < 55) mode = RSP_GOOD;
    else if (roll < 65) mode = RSP_EXCEPTION;
    else if (roll < 72) mode = RSP_BAD_SLAVE;
    else if (roll < 79) mode = RSP_BAD_FUNC;
    else if (roll < 88) mode = RSP_BAD_FIELD;
    else mode = RSP_BAD_CRC;
    build_frame(mode);
    // leave the frame open so the next begin drops it
    if ($urandom_range(19) == 0) begin
      send_prefix($urandom_range(1, frame_q.size() - 1));
      return;
    end
    send_prefix(frame_q.size());
    if ($urandom_range(9) == 0) send_item(rand_item(func_e'($urandom_range(1, 3))));
  endtask

  initial begin
    int unsigned target;
    bit          first;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    quiesce();
    limits[3] = 8'($urandom_range(4, 254));
    // sender light/receiver heavy, then swapped, then free-running
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 69 : 0;
      recv_idle_pct = (ph < 2) ? 69 : (ph < 4) ? 7 : 0;
      write_limit(limits[ph]);
      target = items_sent + RAND_ITEMS / NUM_PHASES;
      first = 1'b1;
      while (items_sent < target) begin
        run_transaction(first, first && ph == 2);
        first = 1'b0;
      end
      quiesce();
    end
    $display("Run covered %0d items and compared %0d result items", items_sent, sb.checked);
    $display("Retry limits: 3 at reset, then 1, 255, 0, %0d, 2 and 3", limits[3]);
    if (sb.pending() != 0) begin
      $error("%0d predicted results never arrived", sb.pending());
      sb.errors += sb.pending();
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
